FILE: rtl/spmq_pkg.sv
package spmq_pkg;

  localparam int unsigned NUM_LEVELS_DEF  = 8;
  localparam int unsigned QUEUE_DEPTH_DEF = 8;
  localparam int unsigned VALUE_WIDTH_DEF = 32;

  localparam int unsigned ITEM_W  = 32;
  localparam int unsigned LEVEL_W = 3;

  typedef enum logic {
    FUNC_ENQ = 1'b0,
    FUNC_DEQ = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

endpackage

FILE: rtl/spmq_store.sv
module spmq_store #(
  parameter int unsigned WORDS = 64,
  parameter int unsigned WIDTH = 32,
  parameter int unsigned AW    = $clog2(WORDS)
) (
  input  logic                clk,
  input  spmq_pkg::mem_ctl_t  ctl,
  input  logic [AW-1:0]       addr,
  input  logic [WIDTH-1:0]    wdata,
  output logic [WIDTH-1:0]    rdata
);
  import spmq_pkg::*;

  logic [WIDTH-1:0] mem [WORDS];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/strict_priority_multi_queue_top.sv
// Strict-priority multi-queue: one circular FIFO per level in a shared single-port
// storage array, with a head pointer and fill count per level. An enqueue
// transaction is accepted, then the full check and storage write are done
// while its result is registered. A dequeue transaction is accepted, then
// the sequencer examines one level's fill count per cycle, starting at
// level 0, and performs a registered storage read of the first non-empty
// level. The input is stalled while a transaction is in progress; a finished
// result waits in the output register, and a new transaction may be accepted while it waits.
// Enqueue to a full level or to a level beyond NUM_LEVELS-1 reports overflow;
// dequeue with every level empty reports underflow. out_value and out_level
// are zero unless a value was dequeued.
module strict_priority_multi_queue_top #(
  parameter int unsigned NUM_LEVELS  = spmq_pkg::NUM_LEVELS_DEF,
  parameter int unsigned QUEUE_DEPTH = spmq_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned VALUE_WIDTH = spmq_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_func,
  input  logic signed [spmq_pkg::ITEM_W-1:0]  in_item_value,
  input  logic [spmq_pkg::LEVEL_W-1:0]        in_level,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          out_status,
  output logic signed [spmq_pkg::ITEM_W-1:0]  out_value,
  output logic [spmq_pkg::LEVEL_W-1:0]        out_level
);
  import spmq_pkg::*;

  localparam int unsigned LW    = $clog2(NUM_LEVELS);
  localparam int unsigned PW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned WORDS = NUM_LEVELS * QUEUE_DEPTH;
  localparam int unsigned AW    = $clog2(WORDS);
  localparam int unsigned XW    = ((LW > LEVEL_W) ? LW : LEVEL_W) + 1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_ENQ  = 5'b00010,
    S_SCAN = 5'b00100,
    S_RD   = 5'b01000,
    S_DUMP = 5'b10000
  } state_t;

  state_t                 state_r, state_nxt;
  func_t                  func_r;
  logic [VALUE_WIDTH-1:0] val_r;
  logic [XW-1:0]          lvl_r;
  logic [LW-1:0]          scan_r;
  logic [PW-1:0]          head_r [NUM_LEVELS];
  logic [CW-1:0]          cnt_r  [NUM_LEVELS];

  logic                   out_valid_r;
  status_t                out_status_r;
  logic [ITEM_W-1:0]      out_value_r;
  logic [LEVEL_W-1:0]     out_level_r;

  logic [LW-1:0]          sel_idx;
  logic [PW-1:0]          cur_head, head_inc, tail, ptr;
  logic [CW-1:0]          cur_cnt;
  logic [CW:0]            tail_sum;
  logic                   lvl_ok, full, out_free, at_last;
  logic [AW-1:0]          addr;
  logic [VALUE_WIDTH-1:0] rd_data;
  mem_ctl_t               mem_ctl;

  logic                   res_valid, res_from_mem, do_enq, do_deq;
  status_t                res_status;

  assign sel_idx  = (state_r == S_ENQ) ? lvl_r[LW-1:0] : scan_r;
  assign cur_head = head_r[sel_idx];
  assign cur_cnt  = cnt_r[sel_idx];
  assign lvl_ok   = lvl_r < XW'(NUM_LEVELS);
  assign full     = !lvl_ok || (cur_cnt == CW'(QUEUE_DEPTH));
  assign tail_sum = (CW+1)'(cur_head) + (CW+1)'(cur_cnt);
  assign tail     = (tail_sum >= (CW+1)'(QUEUE_DEPTH)) ?
                    PW'(tail_sum - (CW+1)'(QUEUE_DEPTH)) : PW'(tail_sum);
  assign head_inc = (cur_head == PW'(QUEUE_DEPTH - 1)) ? '0 : cur_head + 1'b1;
  assign ptr      = (state_r == S_ENQ) ? tail : cur_head;
  assign addr     = AW'(sel_idx) * AW'(QUEUE_DEPTH) + AW'(ptr);
  assign out_free = !out_valid_r || !out_stall;
  assign at_last  = scan_r == LW'(NUM_LEVELS - 1);

  assign in_stall = state_r != S_IDLE;

  always_comb begin
    state_nxt    = state_r;
    mem_ctl      = '0;
    res_valid    = 1'b0;
    res_from_mem = 1'b0;
    res_status   = ST_OK;
    do_enq       = 1'b0;
    do_deq       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = (func_t'(in_func) == FUNC_ENQ) ? S_ENQ : S_SCAN;
        end
      end
      S_ENQ: begin
        if (out_free) begin
          res_valid = 1'b1;
          state_nxt = S_IDLE;
          if (full) begin
            res_status = ST_OVERFLOW;
          end else begin
            mem_ctl.we = 1'b1;
            do_enq     = 1'b1;
          end
        end
      end
      S_SCAN: begin
        if (cur_cnt != '0) begin
          mem_ctl.re = 1'b1;
          do_deq     = 1'b1;
          state_nxt  = S_RD;
        end else if (at_last) begin
          state_nxt = S_DUMP;
        end
      end
      S_RD: begin
        if (out_free) begin
          res_valid    = 1'b1;
          res_from_mem = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_DUMP: begin
        if (out_free) begin
          res_valid  = 1'b1;
          res_status = ST_UNDERFLOW;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      scan_r      <= '0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (res_valid) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_IDLE) begin
        scan_r <= '0;
      end else if (state_r == S_SCAN && cur_cnt == '0 && !at_last) begin
        scan_r <= scan_r + 1'b1;
      end
      if (do_enq) begin
        cnt_r[sel_idx] <= cur_cnt + 1'b1;
      end
      if (do_deq) begin
        cnt_r[sel_idx]  <= cur_cnt - 1'b1;
        head_r[sel_idx] <= head_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      func_r <= func_t'(in_func);
      val_r  <= VALUE_WIDTH'($unsigned(in_item_value));
      lvl_r  <= XW'(in_level);
    end
    if (res_valid) begin
      out_status_r <= res_status;
      out_value_r  <= res_from_mem ? ITEM_W'(rd_data) : '0;
      out_level_r  <= res_from_mem ? LEVEL_W'(scan_r) : '0;
    end
  end

  spmq_store #(
    .WORDS (WORDS),
    .WIDTH (VALUE_WIDTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .ctl   (mem_ctl),
    .addr  (addr),
    .wdata (val_r),
    .rdata (rd_data)
  );

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_value  = out_value_r;
  assign out_level  = out_level_r;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> cnt_r[scan_r] <= CW'(QUEUE_DEPTH))
    else $error("fill count above depth");

  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> head_r[scan_r] <= PW'(QUEUE_DEPTH - 1))
    else $error("head pointer out of range");

  a_func_path: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ENQ |-> func_r == FUNC_ENQ) and
    (state_r == S_SCAN |-> func_r == FUNC_DEQ))
    else $error("sequencer path does not match latched function");

  a_found_read: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN && cur_cnt != '0 |=> state_r == S_RD)
    else $error("non-empty level not read");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_value == '0 && out_level == '0)
    else $error("failed transaction carries payload");
`endif

endmodule
